/* rtl/core/kvs_pkg.sv */
// Shared types and codes for the keyframe vector sampler.
package kvs_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned FRAC_W = 16;
	// One extra quotient bit so a fraction of exactly one can be seen and saturated.
	localparam int unsigned QUOT_W = FRAC_W + 1;

	localparam logic [1:0] MODE_CLEAR  = 2'd0;
	localparam logic [1:0] MODE_APPEND = 2'd1;
	localparam logic [1:0] MODE_SAMPLE = 2'd2;
	localparam logic [1:0] MODE_NOP    = 2'd3;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	// x in [0], y in [1], z in [2]
	typedef logic [2:0][WORD_W-1:0] vec_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_VRD_LO,
		S_VRD_HI,
		S_DIV,
		S_MUL,
		S_ADD,
		S_RESP
	} state_t;

endpackage

/* rtl/core/kvs_cmd_if.sv */
// Command channel: keyframe appends, table clears and sample requests.
interface kvs_cmd_if;
	import kvs_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [1:0]               mode;
	logic [WORD_W-1:0]        key_time;
	logic signed [WORD_W-1:0] key_x;
	logic signed [WORD_W-1:0] key_y;
	logic signed [WORD_W-1:0] key_z;
	logic [WORD_W-1:0]        sample_time;

	modport source (
		output valid, mode, key_time, key_x, key_y, key_z, sample_time,
		input  ready
	);

	modport sink (
		input  valid, mode, key_time, key_x, key_y, key_z, sample_time,
		output ready
	);
endinterface

/* rtl/core/kvs_rsp_if.sv */
// Response channel: status and sampled vector.
interface kvs_rsp_if;
	import kvs_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [1:0]               status;
	logic signed [WORD_W-1:0] out_x;
	logic signed [WORD_W-1:0] out_y;
	logic signed [WORD_W-1:0] out_z;

	modport source (
		output valid, status, out_x, out_y, out_z,
		input  ready
	);

	modport sink (
		input  valid, status, out_x, out_y, out_z,
		output ready
	);
endinterface

/* rtl/core/kvs_frac_div.sv */
// Restoring divider: Q0.16 fraction num/den, one quotient bit per cycle.
module kvs_frac_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [kvs_pkg::WORD_W-1:0]   num,
	input  logic [kvs_pkg::WORD_W-1:0]   den,
	output logic                         done,
	output logic [kvs_pkg::FRAC_W-1:0]   frac
);
	import kvs_pkg::*;

	localparam int unsigned CNT_W = $clog2(QUOT_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WORD_W:0]   rem_q;
	logic [WORD_W-1:0] den_q;
	logic              zero_q;
	logic [QUOT_W-1:0] quot_q;
	logic              ge;
	logic [WORD_W:0]   diff;

	assign ge   = rem_q >= {1'b0, den_q};
	assign diff = rem_q - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// one-cycle pulse after the last quotient bit
			done_q <= busy_q && !start && (cnt_q == CNT_W'(QUOT_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(QUOT_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// num <= den by construction, so the remainder stays below twice den at every step
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, num};
			den_q  <= den;
			zero_q <= (den == '0);
			quot_q <= '0;
		end else if (busy_q) begin
			quot_q <= {quot_q[QUOT_W-2:0], ge};
			rem_q  <= ge ? {diff[WORD_W-1:0], 1'b0} : {rem_q[WORD_W-1:0], 1'b0};
		end
	end

	assign done = done_q;
	assign frac = zero_q             ? '0 :
	              quot_q[QUOT_W-1]   ? '1 : quot_q[FRAC_W-1:0];
endmodule

/* rtl/core/keyframe_vector_sampler_core.sv */
// Keyframe vector sampler: keyframe table in block memory with a linear-blend sample engine.
//
// The block keeps up to MAX_KEYS keyframes (an unsigned Q16.16 time and a signed
// Q16.16 x/y/z vector) in two single-port synchronous memories, one for times and
// one for vectors, appended in arrival order. Every command word yields exactly one
// response word. An append to a full table is dropped with status FULL, and a sample
// on an empty table returns status EMPTY, both with a zero vector. A sample streams
// the time memory, one key per cycle, to find the first pair t[i] <= time <= t[i+1]
// (or the first/last key when the time lies outside), reads both vectors, forms the
// Q0.16 fraction with a 17-step restoring divider (saturated to 0xFFFF, zero for
// equal key times) and blends the three components through one shared 33x17
// multiplier, truncating toward zero. The next command word is taken as soon as the
// engine is back in idle, while the previous response may still wait in the output
// register.
// There is no clearing pass after reset: only entries below the fill count are read.
module keyframe_vector_sampler_core #(
	parameter int unsigned MAX_KEYS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	kvs_cmd_if.sink    cmd,
	kvs_rsp_if.source  rsp
);
	import kvs_pkg::*;

	localparam int unsigned AW    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int unsigned CW    = $clog2(MAX_KEYS + 1);
	localparam int unsigned PROD_W = WORD_W + QUOT_W + 1;

	// storage
	logic [WORD_W-1:0] times_mem [MAX_KEYS];
	vec_t              vec_mem   [MAX_KEYS];
	logic [WORD_W-1:0] times_rd_q;
	vec_t              vec_rd_q;

	// control
	state_t            state_q, state_d;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     iss_q;
	logic              dv_q;
	logic [AW-1:0]     didx_q;
	logic [1:0]        comp_q;
	logic              rsp_valid_q;

	// datapath
	logic [WORD_W-1:0]        tm_q;
	logic [WORD_W-1:0]        prev_q;
	logic [AW-1:0]            lo_q, hi_q;
	logic [WORD_W-1:0]        num_q, den_q;
	vec_t                     v0_q, v1_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [1:0]               res_status_q;
	vec_t                     res_vec_q;
	logic [1:0]               rsp_status_q;
	vec_t                     rsp_vec_q;

	// strobes
	logic              accept;
	logic              full;
	logic              t_rd_en;
	logic              v_rd_en;
	logic [AW-1:0]     v_rd_addr;
	logic              div_start;
	logic              div_done;
	logic [FRAC_W-1:0] frac;
	logic              rsp_load;

	// scan decisions
	logic [CW-1:0]     last_idx;
	logic              first_hit, pair_hit, last_hit, scan_done;

	// blend arithmetic
	logic [WORD_W-1:0]        v0c, v1c;
	logic signed [WORD_W:0]   diff_w;
	logic signed [QUOT_W-1:0] frac_s;
	logic signed [PROD_W-1:0] prod_w;
	logic signed [PROD_W-1:0] rnd_w;
	logic signed [PROD_W-1:0] quo_w;

	assign accept   = cmd.valid && cmd.ready;
	assign full     = (count_q == CW'(MAX_KEYS));
	assign last_idx = count_q - CW'(1);

	// Scan pipeline: index didx_q's time sits in times_rd_q when dv_q is set.
	assign first_hit = dv_q && (didx_q == '0) &&
	                   ((count_q == CW'(1)) || (tm_q <= times_rd_q));
	assign pair_hit  = dv_q && (didx_q != '0) && (prev_q <= tm_q) && (tm_q <= times_rd_q);
	assign last_hit  = dv_q && (didx_q != '0) && !pair_hit && (CW'(didx_q) == last_idx);
	assign scan_done = first_hit || pair_hit || last_hit;

	kvs_frac_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (den_q),
		.done   (div_done),
		.frac   (frac)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (cmd.mode == MODE_SAMPLE && count_q != '0) state_d = S_SCAN;
					else                                          state_d = S_RESP;
				end
			end
			S_SCAN:   if (scan_done) state_d = S_VRD_LO;
			S_VRD_LO: state_d = S_VRD_HI;
			S_VRD_HI: state_d = S_DIV;
			S_DIV:    if (div_done) state_d = S_MUL;
			S_MUL:    state_d = S_ADD;
			S_ADD:    state_d = (comp_q == 2'd2) ? S_RESP : S_MUL;
			S_RESP:   if (!rsp_valid_q || rsp.ready) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		cmd.ready = 1'b0;
		t_rd_en   = 1'b0;
		v_rd_en   = 1'b0;
		v_rd_addr = lo_q;
		div_start = 1'b0;
		rsp_load  = 1'b0;
		unique case (state_q)
			S_IDLE:   cmd.ready = 1'b1;
			S_SCAN:   t_rd_en = (iss_q < count_q);
			S_VRD_LO: begin
				v_rd_en   = 1'b1;
				div_start = 1'b1;
			end
			S_VRD_HI: begin
				v_rd_en   = 1'b1;
				v_rd_addr = hi_q;
			end
			S_RESP:   rsp_load = !rsp_valid_q || rsp.ready;
			default: ;
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (accept && cmd.mode == MODE_APPEND && !full) begin
			times_mem[count_q[AW-1:0]] <= cmd.key_time;
			vec_mem[count_q[AW-1:0]]   <= {cmd.key_z, cmd.key_y, cmd.key_x};
		end
	end

	always_ff @(posedge clk) begin
		if (t_rd_en) times_rd_q <= times_mem[iss_q[AW-1:0]];
		if (v_rd_en) vec_rd_q   <= vec_mem[v_rd_addr];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			iss_q       <= '0;
			dv_q        <= 1'b0;
			comp_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				iss_q  <= '0;
				dv_q   <= 1'b0;
				comp_q <= '0;
				case (cmd.mode)
					MODE_CLEAR:  count_q <= '0;
					MODE_APPEND: if (!full) count_q <= count_q + CW'(1);
					default: ;
				endcase
			end
			if (state_q == S_SCAN) begin
				dv_q <= t_rd_en;
				if (t_rd_en) iss_q <= iss_q + CW'(1);
			end
			if (state_q == S_ADD) comp_q <= comp_q + 2'd1;
			if (rsp_load)       rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
		end
	end

	// blend: one component per MUL/ADD pair
	always_comb begin
		v0c    = v0_q[comp_q];
		v1c    = v1_q[comp_q];
		diff_w = $signed({v1c[WORD_W-1], v1c}) - $signed({v0c[WORD_W-1], v0c});
		frac_s = $signed({1'b0, frac});
		prod_w = diff_w * frac_s;
		// truncate toward zero
		rnd_w  = prod_q + (prod_q[PROD_W-1] ? PROD_W'(2**FRAC_W - 1) : '0);
		quo_w  = rnd_w >>> FRAC_W;
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			tm_q      <= cmd.sample_time;
			res_vec_q <= '0;
			if (cmd.mode == MODE_APPEND && full)               res_status_q <= STATUS_FULL;
			else if (cmd.mode == MODE_SAMPLE && count_q == '0) res_status_q <= STATUS_EMPTY;
			else                                               res_status_q <= STATUS_OK;
		end
		if (state_q == S_SCAN) begin
			if (t_rd_en) didx_q <= iss_q[AW-1:0];
			if (dv_q)    prev_q <= times_rd_q;
			if (first_hit) begin
				lo_q  <= '0;
				hi_q  <= '0;
				num_q <= '0;
				den_q <= '0;
			end else if (pair_hit) begin
				lo_q  <= didx_q - AW'(1);
				hi_q  <= didx_q;
				num_q <= tm_q - prev_q;
				den_q <= times_rd_q - prev_q;
			end else if (last_hit) begin
				lo_q  <= didx_q;
				hi_q  <= didx_q;
				num_q <= '0;
				den_q <= '0;
			end
		end
		if (state_q == S_VRD_HI) v0_q <= vec_rd_q;
		if (state_q == S_DIV)    v1_q <= vec_rd_q;
		if (state_q == S_MUL)    prod_q <= prod_w;
		if (state_q == S_ADD)    res_vec_q[comp_q] <= v0c + quo_w[WORD_W-1:0];
		if (rsp_load) begin
			rsp_status_q <= res_status_q;
			rsp_vec_q    <= res_vec_q;
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.status = rsp_status_q;
	assign rsp.out_x  = rsp_vec_q[0];
	assign rsp.out_y  = rsp_vec_q[1];
	assign rsp.out_z  = rsp_vec_q[2];

	// fill count never runs past the table
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_KEYS))
		else $error("key count exceeds table size");

	// an accepted append into a non-full table grows the count by one
	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.mode == MODE_APPEND && !full |=> count_q == $past(count_q) + CW'(1))
		else $error("append did not advance key count");

	// scan never looks at an entry beyond the fill count
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN && dv_q |-> CW'(didx_q) < count_q)
		else $error("scan read past stored keys");

	// error responses carry a zero vector
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != STATUS_OK |->
			rsp.out_x == '0 && rsp.out_y == '0 && rsp.out_z == '0)
		else $error("error response with nonzero vector");
endmodule
